FILE: sv/bsa_pkg.sv
// bsa_pkg: shared types and constants of the bitmap slot allocator.
// No dependencies; used by bsa_map and bitmap_slot_allocator_core.
`default_nettype none

package bsa_pkg;

    // Default number of slots that storage is built for
    localparam int SLOTS_DEFAULT = 256;

    // Map bits held in one memory word, scanned together
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Slot count register
    localparam int         COUNT_W           = 9;
    localparam logic [8:0] SLOT_COUNT_RESET  = 9'd256;
    localparam int         COUNT_MAX         = 511;

    // Item kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK
    } state_t;

endpackage

`default_nettype wire

FILE: sv/bsa_map.sv
// bsa_map: occupancy map memory, one word of map bits per row, registered read.
// Per-row valid bits make a cleared row read as all zero. Uses bsa_pkg.
`default_nettype none

module bsa_map #(
    parameter  int SLOTS = bsa_pkg::SLOTS_DEFAULT,
    localparam int WORDS = (SLOTS + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS,
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear,
    input  wire logic                           wr_en,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic [bsa_pkg::WORD_BITS-1:0]  wr_data,
    input  wire logic [AW-1:0]                  rd_addr,
    output      logic [bsa_pkg::WORD_BITS-1:0]  rd_data
);

    logic [bsa_pkg::WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]              valid_reg;
    logic [bsa_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // rows never written since the last clear read as all free
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: sv/bitmap_slot_allocator_core.sv
// bitmap_slot_allocator_core: top level of the lowest-free slot allocator.
// Uses bsa_pkg and bsa_map.
//
// Usage
//   Input channel: an item (kind, free_index) is taken at a rising edge with
//   start high and busy low. kind = alloc grants the lowest free slot at or
//   above the search hint; kind = free releases free_index.
//   Result channel: one result item per input item, on status/granted_index
//   for exactly one cycle with done high. The receiver cannot stall.
//   Config: slot_count_we/slot_count_wdata write the slot count; any write
//   clears the whole map and the hint. Write only while idle.
// Sequencing
//   The map is scanned one 32-slot memory word at a time (registered
//   memory read, then find-first-free on the word), so the memory read port
//   sets the rate. From accept to the edge that takes the result:
//     free in range ........ S_READ, then S_CHECK
//     alloc ................ S_READ then S_CHECK for each word scanned, from the hint's word (1..8 words at 256)
//     free out of range, or alloc with the hint already at the end: straight from idle
//   A new item can be taken in the cycle its predecessor's result is shown.
// Reset
//   rst_n clears the map (per-row valid bits), the hint, and sets the slot
//   count to 256. No clearing pass; the block is ready straight away.
`default_nettype none

module bitmap_slot_allocator_core #(
    parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input items
    input  wire logic       start,
    output      logic       busy,
    input  wire logic       kind,
    input  wire logic [7:0] free_index,
    // result items
    output      logic       done,
    output      logic [1:0] status,
    output      logic [7:0] granted_index,
    // slot count register
    input  wire logic       slot_count_we,
    input  wire logic [8:0] slot_count_wdata
);

    localparam int WB    = bsa_pkg::WORD_BITS;
    localparam int BW    = bsa_pkg::BIT_W;
    localparam int CW    = bsa_pkg::COUNT_W;
    localparam int WORDS = (SLOTS + WB - 1) / WB;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    // wide enough for a slot index, the count and one word past the end
    localparam int SW    = (AW + BW + 1 > CW + 1) ? AW + BW + 1 : CW + 1;
    localparam int CAP   = (SLOTS < bsa_pkg::COUNT_MAX) ? SLOTS : bsa_pkg::COUNT_MAX;
    localparam logic [CW-1:0] CAP_C = CW'(CAP);

    bsa_pkg::state_t state_reg, state_next;

    logic [CW-1:0] slot_count_reg;
    logic [CW-1:0] hint_reg,    hint_next;
    logic [AW-1:0] word_reg,    word_next;
    logic          kind_reg,    kind_next;
    logic [7:0]    idx_reg,     idx_next;
    logic          done_reg,    done_next;
    logic [1:0]    status_reg,  status_next;
    logic [7:0]    granted_reg, granted_next;

    logic [CW-1:0] count;
    logic [SW-1:0] count_ext;
    logic [SW-1:0] word_base;
    logic [SW-1:0] next_base;
    logic [SW-1:0] slot_sel;

    logic [WB-1:0] rd_word;
    logic [WB-1:0] in_range;
    logic [WB-1:0] free_bits;
    logic [WB-1:0] lowest;
    logic [BW-1:0] free_bit;
    logic          any_free;

    logic          wr_en;
    logic [WB-1:0] wr_data;

    // active count: register limited to the slots that exist
    assign count     = (slot_count_reg > CAP_C) ? CAP_C : slot_count_reg;
    assign count_ext = SW'(count);
    assign word_base = SW'(word_reg) << BW;
    assign next_base = (SW'(word_reg) + SW'(1)) << BW;

    bsa_map #(
        .SLOTS (SLOTS)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (slot_count_we),
        .wr_en   (wr_en),
        .wr_addr (word_reg),
        .wr_data (wr_data),
        .rd_addr (word_reg),
        .rd_data (rd_word)
    );

    // find first free slot in the current word, limited to the active count
    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            in_range[i] = (word_base + SW'(i)) < count_ext;
        end
        free_bits = ~rd_word & in_range;
        lowest    = free_bits & (~free_bits + WB'(1));
        any_free  = |free_bits;
        free_bit  = '0;
        for (int i = 0; i < WB; i++)
        begin
            if (lowest[i])
            begin
                free_bit = free_bit | BW'(i);
            end
        end
        slot_sel = word_base | SW'(free_bit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bsa_pkg::S_IDLE;
            slot_count_reg <= bsa_pkg::SLOT_COUNT_RESET;
            hint_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            done_reg  <= done_next;
            if (slot_count_we)
            begin
                slot_count_reg <= slot_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        kind_reg    <= kind_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        hint_next    = hint_reg;
        word_next    = word_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        granted_next = granted_reg;
        wr_en        = 1'b0;
        wr_data      = rd_word;

        unique case (state_reg)
            bsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind;
                    idx_next  = free_index;
                    if (kind == bsa_pkg::KIND_FREE)
                    begin
                        if (CW'(free_index) >= count)
                        begin
                            done_next    = 1'b1;
                            status_next  = bsa_pkg::STATUS_RANGE;
                            granted_next = '0;
                        end
                        else
                        begin
                            word_next  = AW'(free_index >> BW);
                            state_next = bsa_pkg::S_READ;
                        end
                    end
                    else
                    begin
                        if (hint_reg >= count)
                        begin
                            // nothing left above the hint
                            hint_next    = count;
                            done_next    = 1'b1;
                            status_next  = bsa_pkg::STATUS_FULL;
                            granted_next = '0;
                        end
                        else
                        begin
                            word_next  = AW'(hint_reg >> BW);
                            state_next = bsa_pkg::S_READ;
                        end
                    end
                end
            end

            bsa_pkg::S_READ:
            begin
                // memory word for word_reg lands in the read register
                state_next = bsa_pkg::S_CHECK;
            end

            bsa_pkg::S_CHECK:
            begin
                if (kind_reg == bsa_pkg::KIND_FREE)
                begin
                    wr_en        = 1'b1;
                    wr_data      = rd_word & ~(WB'(1) << idx_reg[BW-1:0]);
                    if (CW'(idx_reg) < hint_reg)
                    begin
                        hint_next = CW'(idx_reg);
                    end
                    done_next    = 1'b1;
                    status_next  = bsa_pkg::STATUS_OK;
                    granted_next = '0;
                    state_next   = bsa_pkg::S_IDLE;
                end
                else if (any_free)
                begin
                    wr_en        = 1'b1;
                    wr_data      = rd_word | lowest;
                    hint_next    = CW'(slot_sel);
                    done_next    = 1'b1;
                    status_next  = bsa_pkg::STATUS_OK;
                    granted_next = slot_sel[7:0];
                    state_next   = bsa_pkg::S_IDLE;
                end
                else if (next_base >= count_ext)
                begin
                    // scanned to the end of the active slots
                    hint_next    = count;
                    done_next    = 1'b1;
                    status_next  = bsa_pkg::STATUS_FULL;
                    granted_next = '0;
                    state_next   = bsa_pkg::S_IDLE;
                end
                else
                begin
                    word_next  = word_reg + AW'(1);
                    state_next = bsa_pkg::S_READ;
                end
            end

            default:
            begin
                state_next = bsa_pkg::S_IDLE;
            end
        endcase

        // a slot count write empties the map and resets the hint
        if (slot_count_we)
        begin
            hint_next = '0;
        end
    end

    assign busy          = (state_reg != bsa_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;

endmodule

`default_nettype wire
